@@ hw/rtl/jbpoll_pkg.sv @@
// Shared types and constants of the controller poll master.
package jbpoll_pkg;

    localparam int CMD_BITS   = 8;
    localparam int REPLY_BITS = 32;
    localparam int TICK_W     = 10;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COMMAND_BYTE   = 3'd0;
    localparam logic [2:0] CFG_ONE_LOW        = 3'd1;
    localparam logic [2:0] CFG_ZERO_LOW       = 3'd2;
    localparam logic [2:0] CFG_BIT_PERIOD     = 3'd3;
    localparam logic [2:0] CFG_STOP_LOW       = 3'd4;
    localparam logic [2:0] CFG_SAMPLE_DELAY   = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT        = 3'd6;

    typedef struct packed {
        logic [7:0]        command_byte;
        logic [7:0]        one_low_ticks;
        logic [7:0]        zero_low_ticks;
        logic [7:0]        bit_period_ticks;
        logic [7:0]        stop_low_ticks;
        logic [7:0]        sample_delay_ticks;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] stick_y;
        logic [7:0] stick_x;
        logic [7:0] buttons_second;
        logic [7:0] buttons_first;
        logic       timed_out;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_result;

endpackage

@@ hw/rtl/jbpoll_core.sv @@
// Poll sequencer: line timing state and the result of each accepted word.
module jbpoll_core
    import jbpoll_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_req_type,
    input  logic    i_line_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_TX_LOW      = 3'd1;
    localparam logic [2:0] PH_TX_HIGH     = 3'd2;
    localparam logic [2:0] PH_STOP_LOW    = 3'd3;
    localparam logic [2:0] PH_WAIT_HIGH   = 3'd4;
    localparam logic [2:0] PH_WAIT_FALL   = 3'd5;
    localparam logic [2:0] PH_SAMPLE      = 3'd6;
    localparam logic [2:0] PH_WAIT_REHIGH = 3'd7;

    logic [2:0]            r_phase,     n_phase;
    logic [TICK_W-1:0]     r_tick,      n_tick;
    logic [CMD_BITS-1:0]   r_tx_shift,  n_tx_shift;
    logic [3:0]            r_tx_left,   n_tx_left;
    logic [REPLY_BITS-1:0] r_rx_bits,   n_rx_bits;
    logic [5:0]            r_rx_count,  n_rx_count;

    logic [TICK_W-1:0] tick_inc;
    logic [7:0]        low_len;
    logic [3:0]        left_dec;
    logic [5:0]        count_inc;
    logic [4:0]        bit_idx;
    logic              done;
    logic              tout;

    assign tick_inc  = r_tick + TICK_W'(1);
    assign low_len   = r_tx_shift[CMD_BITS-1] ? i_cfg.one_low_ticks : i_cfg.zero_low_ticks;
    assign left_dec  = r_tx_left - 4'd1;
    assign count_inc = r_rx_count + 6'd1;
    // The first reply bit lands in the top bit of the store.
    assign bit_idx   = 5'(REPLY_BITS - 1) - r_rx_count[4:0];

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_tx_shift = r_tx_shift;
        n_tx_left  = r_tx_left;
        n_rx_bits  = r_rx_bits;
        n_rx_count = r_rx_count;
        done       = 1'b0;
        tout       = 1'b0;

        if (i_req_type) begin
            // A start request during a running poll is ignored.
            if (r_phase == PH_IDLE) begin
                n_tx_shift = i_cfg.command_byte;
                n_tx_left  = 4'(CMD_BITS);
                n_tick     = '0;
                n_rx_bits  = '0;
                n_rx_count = '0;
                n_phase    = PH_TX_LOW;
            end
        end else begin
            case (r_phase)
                PH_TX_LOW: begin
                    n_tick = tick_inc;
                    if (tick_inc >= TICK_W'(low_len)) begin
                        n_phase = PH_TX_HIGH;
                    end
                end
                PH_TX_HIGH: begin
                    n_tick = tick_inc;
                    if (tick_inc >= TICK_W'(i_cfg.bit_period_ticks)) begin
                        n_tick     = '0;
                        n_tx_shift = {r_tx_shift[CMD_BITS-2:0], 1'b0};
                        n_tx_left  = left_dec;
                        n_phase    = (left_dec == 4'd0) ? PH_STOP_LOW : PH_TX_LOW;
                    end
                end
                PH_STOP_LOW: begin
                    n_tick = tick_inc;
                    if (tick_inc >= TICK_W'(i_cfg.stop_low_ticks)) begin
                        n_tick  = '0;
                        n_phase = PH_WAIT_HIGH;
                    end
                end
                PH_WAIT_HIGH, PH_WAIT_REHIGH: begin
                    if (i_line_level) begin
                        n_tick  = '0;
                        n_phase = PH_WAIT_FALL;
                    end else begin
                        n_tick = tick_inc;
                        if (tick_inc >= i_cfg.timeout_ticks) begin
                            done = 1'b1;
                            tout = 1'b1;
                        end
                    end
                end
                PH_WAIT_FALL: begin
                    if (!i_line_level) begin
                        n_tick  = '0;
                        n_phase = PH_SAMPLE;
                    end else begin
                        n_tick = tick_inc;
                        if (tick_inc >= i_cfg.timeout_ticks) begin
                            done = 1'b1;
                            tout = 1'b1;
                        end
                    end
                end
                PH_SAMPLE: begin
                    n_tick = tick_inc;
                    if (tick_inc >= TICK_W'(i_cfg.sample_delay_ticks)) begin
                        if (r_rx_count < 6'(REPLY_BITS) && i_line_level) begin
                            n_rx_bits[bit_idx] = 1'b1;
                        end
                        n_rx_count = count_inc;
                        n_tick     = '0;
                        if (count_inc >= 6'(REPLY_BITS)) begin
                            done = 1'b1;
                        end else begin
                            n_phase = PH_WAIT_REHIGH;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (done) begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_tx_shift <= '0;
            r_tx_left  <= '0;
            r_rx_bits  <= '0;
            r_rx_count <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_tx_shift <= n_tx_shift;
            r_tx_left  <= n_tx_left;
            r_rx_bits  <= n_rx_bits;
            r_rx_count <= n_rx_count;
        end
    end

    // The result shows the state as it stands after this word.
    always_comb begin
        o_result.drive_low      = (n_phase == PH_TX_LOW) || (n_phase == PH_STOP_LOW);
        o_result.busy_res       = (n_phase != PH_IDLE);
        o_result.done_res       = done;
        o_result.timed_out      = tout;
        o_result.buttons_first  = n_rx_bits[31:24];
        o_result.buttons_second = n_rx_bits[23:16];
        o_result.stick_x        = n_rx_bits[15:8];
        o_result.stick_y        = n_rx_bits[7:0];
    end

endmodule

@@ hw/rtl/joybus_controller_poll_master.sv @@
// Top level of the single-wire controller poll master.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: line_level
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata: flags and the four reply bytes
//  cfg      in   i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
// Each input word is one timing tick or a start request;
// the sequencer state moves on the accepting edge and its result is held in one
// output register. A new word is accepted whenever that register is empty or being
// drained, so ticks stream at one per cycle. A stall on m_axis holds the result and
// backs up s_axis. Synchronous reset returns the sequencer to idle and the
// configuration registers to their defaults and empties the output register.
module joybus_controller_poll_master
    import jbpoll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] line_level, [7:1] zero
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [3] timed_out, [11:4] buttons_first,
                                        // [19:12] buttons_second, [27:20] stick_x,
                                        // [35:28] stick_y, [39:36] zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    t_result core_result;
    t_result r_out_data;
    logic    r_out_valid;
    logic    accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.command_byte       <= 8'd1;
            r_cfg.one_low_ticks      <= 8'd5;
            r_cfg.zero_low_ticks     <= 8'd40;
            r_cfg.bit_period_ticks   <= 8'd48;
            r_cfg.stop_low_ticks     <= 8'd16;
            r_cfg.sample_delay_ticks <= 8'd32;
            r_cfg.timeout_ticks      <= 10'd252;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COMMAND_BYTE: r_cfg.command_byte       <= i_cfg_wdata[7:0];
                CFG_ONE_LOW:      r_cfg.one_low_ticks      <= i_cfg_wdata[7:0];
                CFG_ZERO_LOW:     r_cfg.zero_low_ticks     <= i_cfg_wdata[7:0];
                CFG_BIT_PERIOD:   r_cfg.bit_period_ticks   <= i_cfg_wdata[7:0];
                CFG_STOP_LOW:     r_cfg.stop_low_ticks     <= i_cfg_wdata[7:0];
                CFG_SAMPLE_DELAY: r_cfg.sample_delay_ticks <= i_cfg_wdata[7:0];
                CFG_TIMEOUT:      r_cfg.timeout_ticks      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    jbpoll_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (s_axis_tuser),
        .i_line_level (s_axis_tdata[0]),
        .i_cfg        (r_cfg),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_data};

endmodule

@@ hw/rtl/jbpoll_checker.sv @@
// Port-level checks of the poll master, bound to the top level.
module jbpoll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A finishing word always leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
        else $error("done word still shows busy");

    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
        else $error("timeout flag without done");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("line driven low while idle");

    // An accepted word must yield a result word on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

endmodule

bind joybus_controller_poll_master jbpoll_checker u_jbpoll_checker (.*);

@@ sim/tb_joybus_controller_poll_master.sv @@
// Self-checking testbench for the single-wire controller poll master.
`timescale 1ns / 1ps

module tb_joybus_controller_poll_master;
    import jbpoll_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TX_LOW, PH_TX_HIGH, PH_STOP_LOW,
        PH_WAIT_HIGH, PH_WAIT_FALL, PH_SAMPLE, PH_WAIT_REHIGH
    } poll_phase_e;

    typedef struct {
        poll_phase_e  phase;
        logic [9:0]   ticks;
        logic [7:0]   tx_shift;
        logic [3:0]   tx_left;
        logic [31:0]  rx_bits;
        logic [5:0]   rx_count;
    } poll_state_t;

    typedef struct {
        logic start;
        logic line;
    } line_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [0] line_level, [7:1] zero
    logic        s_axis_tuser = 1'b0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [3] timed_out, [11:4] buttons_first,
                                        // [19:12] buttons_second, [27:20] stick_x,
                                        // [35:28] stick_y, [39:36] zero
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = 3'd0;
    logic [9:0]  i_cfg_wdata = 10'd0;

    joybus_controller_poll_master uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    t_cfg        timing;
    poll_state_t gen_st;
    poll_state_t chk_st;
    line_word_t  tick_words[$];
    t_result     predicted_words[$];
    int          errors = 0;
    int          words_planned = 0;
    logic        in_taken = 1'b0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          rx_cycle = 0;

    function automatic poll_state_t idle_state();
        poll_state_t st;
        st.phase = PH_IDLE;
        st.ticks = '0;
        st.tx_shift = '0;
        st.tx_left = '0;
        st.rx_bits = '0;
        st.rx_count = '0;
        return st;
    endfunction

    // One tick or start request; returns the result word the block shows after it.
    function automatic t_result poll_step(inout poll_state_t st, input t_cfg c,
                                          input logic start, input logic line);
        t_result r;
        logic [7:0] low_len;
        logic fin;
        logic tout;
        fin = 1'b0;
        tout = 1'b0;
        if (start) begin
            if (st.phase == PH_IDLE) begin
                st.tx_shift = c.command_byte;
                st.tx_left = 4'(CMD_BITS);
                st.ticks = '0;
                st.rx_bits = '0;
                st.rx_count = '0;
                st.phase = PH_TX_LOW;
            end
        end else begin
            case (st.phase)
                PH_TX_LOW: begin
                    st.ticks = st.ticks + 10'd1;
                    low_len = st.tx_shift[7] ? c.one_low_ticks : c.zero_low_ticks;
                    if (st.ticks >= 10'(low_len)) st.phase = PH_TX_HIGH;
                end
                PH_TX_HIGH: begin
                    st.ticks = st.ticks + 10'd1;
                    if (st.ticks >= 10'(c.bit_period_ticks)) begin
                        st.ticks = '0;
                        st.tx_shift = st.tx_shift << 1;
                        st.tx_left = st.tx_left - 4'd1;
                        st.phase = (st.tx_left == 4'd0) ? PH_STOP_LOW : PH_TX_LOW;
                    end
                end
                PH_STOP_LOW: begin
                    st.ticks = st.ticks + 10'd1;
                    if (st.ticks >= 10'(c.stop_low_ticks)) begin
                        st.ticks = '0;
                        st.phase = PH_WAIT_HIGH;
                    end
                end
                PH_WAIT_HIGH, PH_WAIT_REHIGH: begin
                    if (line) begin
                        st.ticks = '0;
                        st.phase = PH_WAIT_FALL;
                    end else begin
                        st.ticks = st.ticks + 10'd1;
                        if (st.ticks >= c.timeout_ticks) begin
                            fin = 1'b1;
                            tout = 1'b1;
                        end
                    end
                end
                PH_WAIT_FALL: begin
                    if (!line) begin
                        st.ticks = '0;
                        st.phase = PH_SAMPLE;
                    end else begin
                        st.ticks = st.ticks + 10'd1;
                        if (st.ticks >= c.timeout_ticks) begin
                            fin = 1'b1;
                            tout = 1'b1;
                        end
                    end
                end
                PH_SAMPLE: begin
                    st.ticks = st.ticks + 10'd1;
                    if (st.ticks >= 10'(c.sample_delay_ticks)) begin
                        if (int'(st.rx_count) < REPLY_BITS && line)
                            st.rx_bits[REPLY_BITS - 1 - int'(st.rx_count)] = 1'b1;
                        st.rx_count = st.rx_count + 6'd1;
                        st.ticks = '0;
                        if (int'(st.rx_count) >= REPLY_BITS) fin = 1'b1;
                        else st.phase = PH_WAIT_REHIGH;
                    end
                end
                default: ;
            endcase
            if (fin) begin
                st.phase = PH_IDLE;
                st.ticks = '0;
            end
        end
        r.drive_low = (st.phase == PH_TX_LOW || st.phase == PH_STOP_LOW);
        r.busy_res = (st.phase != PH_IDLE);
        r.done_res = fin;
        r.timed_out = tout;
        r.buttons_first = st.rx_bits[31:24];
        r.buttons_second = st.rx_bits[23:16];
        r.stick_x = st.rx_bits[15:8];
        r.stick_y = st.rx_bits[7:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Queues one word and advances the planning copy of the sequencer with it.
    task automatic queue_word(input logic start, input logic line);
        line_word_t w;
        t_result    unused;
        w.start = start;
        w.line = line;
        tick_words.push_back(w);
        words_planned++;
        unused = poll_step(gen_st, timing, start, line);
    endtask

    // Runs the poll under way to its end, playing the controller's side of the line. With
    // aborts set, the line is held at the wrong level once abort_at reply bits are in.
    task automatic finish_poll(input bit aborts, input int abort_at);
        logic lvl;
        bit   spare;
        bit   stalled;
        while (gen_st.phase != PH_IDLE) begin
            spare = int'(gen_st.ticks) + 1 < int'(timing.timeout_ticks);
            stalled = aborts && int'(gen_st.rx_count) == abort_at;
            lvl = 1'($urandom_range(0, 1));
            case (gen_st.phase)
                PH_WAIT_HIGH, PH_WAIT_REHIGH:
                    lvl = stalled ? 1'b0 :
                          (spare && $urandom_range(0, 99) < 40) ? 1'b0 : 1'b1;
                PH_WAIT_FALL:
                    lvl = stalled ? 1'b1 :
                          (spare && $urandom_range(0, 99) < 40) ? 1'b1 : 1'b0;
                default: ;
            endcase
            // A start now and then while busy must be ignored.
            queue_word(1'($urandom_range(0, 99) < 3), lvl);
        end
    endtask

    // Plans one whole poll from a few idle ticks and a start request.
    task automatic plan_poll(input bit aborts, input int abort_at);
        repeat ($urandom_range(0, 3)) queue_word(1'b0, 1'($urandom_range(0, 1)));
        queue_word(1'b1, 1'($urandom_range(0, 1)));
        finish_poll(aborts, abort_at);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_COMMAND_BYTE: timing.command_byte = val[7:0];
            CFG_ONE_LOW:      timing.one_low_ticks = val[7:0];
            CFG_ZERO_LOW:     timing.zero_low_ticks = val[7:0];
            CFG_BIT_PERIOD:   timing.bit_period_ticks = val[7:0];
            CFG_STOP_LOW:     timing.stop_low_ticks = val[7:0];
            CFG_SAMPLE_DELAY: timing.sample_delay_ticks = val[7:0];
            CFG_TIMEOUT:      timing.timeout_ticks = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input int cmd, input int one, input int zero, input int period,
                              input int stop, input int delay, input int limit);
        write_reg(CFG_COMMAND_BYTE, 10'(cmd));
        write_reg(CFG_ONE_LOW, 10'(one));
        write_reg(CFG_ZERO_LOW, 10'(zero));
        write_reg(CFG_BIT_PERIOD, 10'(period));
        write_reg(CFG_STOP_LOW, 10'(stop));
        write_reg(CFG_SAMPLE_DELAY, 10'(delay));
        write_reg(CFG_TIMEOUT, 10'(limit));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_all_returned();
        wait (tick_words.size() == 0 && !s_axis_tvalid && predicted_words.size() == 0);
        @(negedge i_clk);
    endtask

    // Sender: bursts of words with gaps between them.
    always @(negedge i_clk) begin
        line_word_t w;
        logic v;
        logic u;
        logic d;
        v = s_axis_tvalid;
        u = s_axis_tuser;
        d = s_axis_tdata[0];
        if (!i_rst_n) begin
            v = 1'b0;
        end else begin
            if (v && in_taken) v = 1'b0;
            if (!v) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tick_words.size() > 0) begin
                    w = tick_words.pop_front();
                    v = 1'b1;
                    u = w.start;
                    d = w.line;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_axis_tvalid <= v;
        s_axis_tuser <= u;
        s_axis_tdata <= {7'd0, d};
    end

    // Receiver: a regular long hold-off, otherwise a rotating stall pattern.
    always @(negedge i_clk) begin
        logic rdy;
        rx_cycle++;
        if (rx_cycle % 1024 >= 300 && rx_cycle % 1024 < 400) begin
            rdy = 1'b0;
        end else begin
            case ((rx_cycle / 128) % 4)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 99) < 70;
                2: rdy = (rx_cycle % 3) != 0;
                default: rdy = $urandom_range(0, 99) < 30;
            endcase
        end
        m_axis_tready <= rdy;
    end

    // Result words are checked before new predictions are queued in the same cycle.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                got = m_axis_tdata[35:0];
                if (predicted_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("drive_low", want.drive_low, got.drive_low);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("buttons_first", want.buttons_first, got.buttons_first);
                    check_field("buttons_second", want.buttons_second, got.buttons_second);
                    check_field("stick_x", want.stick_x, got.stick_x);
                    check_field("stick_y", want.stick_y, got.stick_y);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                predicted_words.push_back(poll_step(chk_st, timing, s_axis_tuser,
                                                    s_axis_tdata[0]));
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        timing = '{command_byte: 8'd1, one_low_ticks: 8'd5, zero_low_ticks: 8'd40,
                   bit_period_ticks: 8'd48, stop_low_ticks: 8'd16,
                   sample_delay_ticks: 8'd32, timeout_ticks: 10'd252};
        gen_st = idle_state();
        chk_st = idle_state();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: ticks while idle, then the first bit cells of a poll.
        queue_word(1'b0, 1'b0);
        queue_word(1'b0, 1'b1);
        queue_word(1'b1, 1'b0);
        repeat (100) queue_word(1'b0, 1'($urandom_range(0, 1)));
        wait_all_returned();

        // Shortest legal timing, switched in while that poll is still sending.
        set_timing(8'h00, 1, 1, 2, 1, 1, 1);
        finish_poll(1'b1, 1);
        plan_poll(1'b0, 0);
        wait_all_returned();

        // Every register zero: each count ends after a single tick.
        set_timing(0, 0, 0, 0, 0, 0, 0);
        plan_poll(1'b1, 2);
        wait_all_returned();

        // Low times at or above the bit period.
        set_timing(8'hA5, 3, 4, 2, 2, 2, 5);
        plan_poll(1'b1, 4);
        wait_all_returned();

        while (words_planned < 450) begin
            set_timing($urandom_range(0, 255), $urandom_range(1, 4), $urandom_range(1, 6),
                       $urandom_range(2, 8), $urandom_range(1, 4), $urandom_range(1, 4),
                       $urandom_range(1, 12));
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 99) < 70) plan_poll(1'b0, 0);
                else plan_poll(1'b1, $urandom_range(0, 31));
            end
            wait_all_returned();
        end

        repeat (20) @(posedge i_clk);
        if (predicted_words.size() != 0) begin
            $error("%0d result words never arrived", predicted_words.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
